// ----- rtl/phsq_pkg.sv -----
package phsq_pkg;

   // Widest clamped limit: CHUNK_POSTS is at most 8, so the limit is at most 64
   localparam int LIM_W = 7;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_NEWEST = 2'd1,
      ACT_AFTER  = 2'd2,
      ACT_SINCE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_GAP    = 2'd1,
      STAT_REJECT = 2'd2
   } status_type;

   // Classified request as it waits between front and back
   typedef struct packed {
      action_type        action;
      logic              is_reject;
      logic [31:0]       key;
      logic [31:0]       tval;
      logic [31:0]       payload;
      logic [15:0]       seq;
      logic [7:0]        client;
      logic [LIM_W-1:0]  lim;
   } req_type;

   // One result item
   typedef struct packed {
      logic [15:0] echo_seq;
      logic [7:0]  echo_client;
      status_type  status;
      logic        post_valid;
      logic [31:0] post_id;
      logic [31:0] post_time;
      logic [31:0] payload;
      logic        chunk_end;
      logic        last;
      logic [31:0] appended;
      logic [31:0] dropped;
   } rsp_type;

endpackage

// ----- rtl/phsq_fifo.sv -----
module phsq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/phsq_front.sv -----
module phsq_front
   import phsq_pkg::*;
#(
   parameter int CHUNK_POSTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  action,
   input  logic [31:0] key_post_id,
   input  logic [31:0] time_value,
   input  logic [31:0] post_payload,
   input  logic [15:0] seq_num,
   input  logic [7:0]  client_slot,
   input  logic [15:0] limit,
   input  logic        q_pop,
   output req_type     q_data,
   output logic        q_empty
);

   localparam int MAX_LIM = CHUNK_POSTS * 8;

   req_type          cls;
   logic [LIM_W-1:0] lim_c;

   // Clamp the limit to 1..MAX_LIM
   always_comb begin
      if (limit == 16'd0) begin
         lim_c = LIM_W'(1);
      end else if (limit > 16'(MAX_LIM)) begin
         lim_c = LIM_W'(MAX_LIM);
      end else begin
         lim_c = limit[LIM_W-1:0];
      end
   end

   // Classify the item
   always_comb begin
      cls.action    = action_type'(action);
      cls.is_reject = (action_type'(action) == ACT_APPEND) && (key_post_id == 32'd0);
      cls.key       = key_post_id;
      cls.tval      = time_value;
      cls.payload   = post_payload;
      cls.seq       = seq_num;
      cls.client    = client_slot;
      cls.lim       = lim_c;
   end

   phsq_fifo #(
      .WIDTH($bits(req_type)),
      .DEPTH(2)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cls),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

endmodule

// ----- rtl/phsq_back.sv -----
module phsq_back
   import phsq_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int CHUNK_POSTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  req_type q_data,
   output logic    q_pop,
   input  logic    r_full,
   output logic    r_push,
   output rsp_type r_data
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CHW = (CHUNK_POSTS > 1) ? $clog2(CHUNK_POSTS) : 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DUP    = 8'b0000_0010,
      ST_WRITE  = 8'b0000_0100,
      ST_SURVEY = 8'b0000_1000,
      ST_DECIDE = 8'b0001_0000,
      ST_FIND   = 8'b0010_0000,
      ST_PICK   = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   // Ring memory
   logic [31:0] slot_id   [CAPACITY];
   logic [31:0] slot_time [CAPACITY];
   logic [31:0] slot_pay  [CAPACITY];

   state_type        state_ff, state_in;
   req_type          cur_ff, cur_in;
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic             wrapped_ff, wrapped_in;
   logic [31:0]      appends_ff, appends_in;
   logic [31:0]      drops_ff, drops_in;

   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   logic             issue_ff, issue_in;
   logic             rd_vld_ff, rd_end_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic [31:0]      id_rd_ff, time_rd_ff, pay_rd_ff;

   logic             hit_ff, hit_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [31:0]      min_ff, min_in;
   logic             anyv_ff, anyv_in;
   logic [31:0]      prev_ff, prev_in;
   logic             found_ff, found_in;
   logic [31:0]      best_id_ff, best_id_in;
   logic [31:0]      best_time_ff, best_time_in;
   logic [31:0]      best_pay_ff, best_pay_in;
   logic [CW-1:0]    skip_ff, skip_in;
   logic [LIM_W-1:0] emit_ff, emit_in;
   logic [LIM_W-1:0] k_ff, k_in;
   logic [CHW-1:0]   chunk_ff, chunk_in;

   status_type       o_status_ff, o_status_in;
   logic             o_valid_ff, o_valid_in;
   logic [31:0]      o_id_ff, o_id_in;
   logic [31:0]      o_time_ff, o_time_in;
   logic [31:0]      o_pay_ff, o_pay_in;
   logic             o_ce_ff, o_ce_in;
   logic             o_last_ff, o_last_in;

   logic             slot_v, match, scan_done, mem_we, fin;

   // Data stage of the scan: slot is live when below the fill pointer or ring wrapped
   assign slot_v    = rd_vld_ff && (wrapped_ff || (rd_idx_ff < wptr_ff));
   assign scan_done = rd_vld_ff && rd_end_ff;
   assign mem_we    = (state_ff == ST_WRITE);
   assign fin       = ((k_ff + 1'b1) == emit_ff);

   always_comb begin
      case (cur_ff.action)
         ACT_NEWEST: match = slot_v;
         ACT_AFTER:  match = slot_v && (id_rd_ff > cur_ff.key);
         ACT_SINCE:  match = slot_v && (time_rd_ff > cur_ff.tval);
         default:    match = 1'b0;
      endcase
   end

   assign q_pop  = (state_ff == ST_IDLE) && !q_empty;
   assign r_push = (state_ff == ST_OUT) && !r_full;

   always_comb begin
      r_data.echo_seq    = cur_ff.seq;
      r_data.echo_client = cur_ff.client;
      r_data.status      = o_status_ff;
      r_data.post_valid  = o_valid_ff;
      r_data.post_id     = o_id_ff;
      r_data.post_time   = o_time_ff;
      r_data.payload     = o_pay_ff;
      r_data.chunk_end   = o_ce_ff;
      r_data.last        = o_last_ff;
      r_data.appended    = appends_ff;
      r_data.dropped     = drops_ff;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      wptr_in      = wptr_ff;
      wrapped_in   = wrapped_ff;
      appends_in   = appends_ff;
      drops_in     = drops_ff;
      rd_addr_in   = rd_addr_ff + 1'b1;
      issue_in     = issue_ff && (rd_addr_ff != AW'(CAPACITY - 1));
      hit_in       = hit_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      anyv_in      = anyv_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      best_id_in   = best_id_ff;
      best_time_in = best_time_ff;
      best_pay_in  = best_pay_ff;
      skip_in      = skip_ff;
      emit_in      = emit_ff;
      k_in         = k_ff;
      chunk_in     = chunk_ff;
      o_status_in  = o_status_ff;
      o_valid_in   = o_valid_ff;
      o_id_in      = o_id_ff;
      o_time_in    = o_time_ff;
      o_pay_in     = o_pay_ff;
      o_ce_in      = o_ce_ff;
      o_last_in    = o_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               cur_in      = q_data;
               o_status_in = STAT_OK;
               o_valid_in  = 1'b0;
               o_id_in     = '0;
               o_time_in   = '0;
               o_pay_in    = '0;
               o_ce_in     = 1'b0;
               o_last_in   = 1'b1;
               rd_addr_in  = '0;
               if (q_data.is_reject) begin
                  o_status_in = STAT_REJECT;
                  state_in    = ST_OUT;
               end else if (q_data.action == ACT_APPEND) begin
                  hit_in   = 1'b0;
                  issue_in = 1'b1;
                  state_in = ST_DUP;
               end else begin
                  count_in = '0;
                  min_in   = '1;
                  anyv_in  = 1'b0;
                  issue_in = 1'b1;
                  state_in = ST_SURVEY;
               end
            end
         end
         ST_DUP: begin
            if (slot_v && (id_rd_ff == cur_ff.key)) begin
               hit_in = 1'b1;
            end
            if (scan_done) begin
               state_in = (hit_in) ? ST_OUT : ST_WRITE;
            end
         end
         ST_WRITE: begin
            // Memory write happens in this cycle
            wptr_in    = (wptr_ff == AW'(CAPACITY - 1)) ? '0 : wptr_ff + 1'b1;
            wrapped_in = wrapped_ff || (wptr_ff == AW'(CAPACITY - 1));
            appends_in = appends_ff + 32'd1;
            if (wrapped_in) begin
               drops_in = drops_ff + 32'd1;
            end
            state_in = ST_OUT;
         end
         ST_SURVEY: begin
            if (match) begin
               count_in = count_ff + 1'b1;
            end
            if (slot_v) begin
               anyv_in = 1'b1;
               if (id_rd_ff < min_ff) begin
                  min_in = id_rd_ff;
               end
            end
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            prev_in  = '0;
            found_in = 1'b0;
            k_in     = '0;
            chunk_in = '0;
            skip_in  = '0;
            if (32'(count_ff) < 32'(cur_ff.lim)) begin
               emit_in = LIM_W'(count_ff);
            end else begin
               emit_in = cur_ff.lim;
               if (cur_ff.action == ACT_NEWEST) begin
                  skip_in = count_ff - CW'(cur_ff.lim);
               end
            end
            if ((cur_ff.action == ACT_AFTER) && (cur_ff.key != 32'd0) && anyv_ff &&
                (cur_ff.key < min_ff)) begin
               o_status_in = STAT_GAP;
               state_in    = ST_OUT;
            end else if (count_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               rd_addr_in = '0;
               issue_in   = 1'b1;
               state_in   = ST_FIND;
            end
         end
         ST_FIND: begin
            // Smallest matching id above the previous pick
            if (match && (id_rd_ff > prev_ff) && (!found_ff || (id_rd_ff < best_id_ff))) begin
               found_in     = 1'b1;
               best_id_in   = id_rd_ff;
               best_time_in = time_rd_ff;
               best_pay_in  = pay_rd_ff;
            end
            if (scan_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            prev_in  = best_id_ff;
            found_in = 1'b0;
            if (skip_ff != '0) begin
               skip_in    = skip_ff - 1'b1;
               rd_addr_in = '0;
               issue_in   = 1'b1;
               state_in   = ST_FIND;
            end else begin
               o_valid_in = 1'b1;
               o_id_in    = best_id_ff;
               o_time_in  = best_time_ff;
               o_pay_in   = best_pay_ff;
               o_ce_in    = fin || (chunk_ff == CHW'(CHUNK_POSTS - 1));
               o_last_in  = fin;
               k_in       = k_ff + 1'b1;
               chunk_in   = (chunk_ff == CHW'(CHUNK_POSTS - 1)) ? '0 : chunk_ff + 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!r_full) begin
               if (o_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr_in = '0;
                  issue_in   = 1'b1;
                  state_in   = ST_FIND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wptr_ff    <= '0;
         wrapped_ff <= 1'b0;
         appends_ff <= '0;
         drops_ff   <= '0;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wptr_ff    <= wptr_in;
         wrapped_ff <= wrapped_in;
         appends_ff <= appends_in;
         drops_ff   <= drops_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= issue_ff;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rd_addr_ff   <= rd_addr_in;
      rd_idx_ff    <= rd_addr_ff;
      rd_end_ff    <= (rd_addr_ff == AW'(CAPACITY - 1));
      hit_ff       <= hit_in;
      count_ff     <= count_in;
      min_ff       <= min_in;
      anyv_ff      <= anyv_in;
      prev_ff      <= prev_in;
      found_ff     <= found_in;
      best_id_ff   <= best_id_in;
      best_time_ff <= best_time_in;
      best_pay_ff  <= best_pay_in;
      skip_ff      <= skip_in;
      emit_ff      <= emit_in;
      k_ff         <= k_in;
      chunk_ff     <= chunk_in;
      o_status_ff  <= o_status_in;
      o_valid_ff   <= o_valid_in;
      o_id_ff      <= o_id_in;
      o_time_ff    <= o_time_in;
      o_pay_ff     <= o_pay_in;
      o_ce_ff      <= o_ce_in;
      o_last_ff    <= o_last_in;
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_id[wptr_ff]   <= cur_ff.key;
         slot_time[wptr_ff] <= cur_ff.tval;
         slot_pay[wptr_ff]  <= cur_ff.payload;
      end
      if (issue_ff) begin
         id_rd_ff   <= slot_id[rd_addr_ff];
         time_rd_ff <= slot_time[rd_addr_ff];
         pay_rd_ff  <= slot_pay[rd_addr_ff];
      end
   end

endmodule

// ----- rtl/post_history_store_query.sv -----
// Post history store: a ring of CAPACITY posts (id, timestamp, payload) with
// append and three listing queries (newest N, after an id, since a time).
// Requests queue on the push/full side and results leave on the empty/pop
// side, one post per result in ascending id order. All work goes through one
// read port of the ring memory, one full pass over the ring per step: an
// append takes one pass (duplicate check), then a write unless the id is
// stored; a query takes one survey pass and a decision, then one pass per
// post emitted, and for newest posts also one pass per older post skipped,
// with a pick after each pass and a hand-off per result.
// Reset leaves the store empty at once (fill pointer), with no clearing pass.
module post_history_store_query
   import phsq_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int CHUNK_POSTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key_post_id,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_post_payload,
   input  logic [15:0] req_seq_num,
   input  logic [7:0]  req_client_slot,
   input  logic [15:0] req_limit,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_echo_seq,
   output logic [7:0]  rsp_echo_client,
   output logic [1:0]  rsp_status,
   output logic        rsp_post_valid,
   output logic [31:0] rsp_out_post_id,
   output logic [31:0] rsp_out_post_time,
   output logic [31:0] rsp_out_payload,
   output logic        rsp_chunk_end,
   output logic        rsp_last,
   output logic [31:0] rsp_appended_count,
   output logic [31:0] rsp_dropped_count
);

   req_type q_data;
   logic    q_pop, q_empty;
   rsp_type r_data, r_head;
   logic    r_push, r_full;

   phsq_front #(
      .CHUNK_POSTS(CHUNK_POSTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .action       (req_action),
      .key_post_id  (req_key_post_id),
      .time_value   (req_time_value),
      .post_payload (req_post_payload),
      .seq_num      (req_seq_num),
      .client_slot  (req_client_slot),
      .limit        (req_limit),
      .q_pop        (q_pop),
      .q_data       (q_data),
      .q_empty      (q_empty)
   );

   phsq_back #(
      .CAPACITY    (CAPACITY),
      .CHUNK_POSTS (CHUNK_POSTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .r_full  (r_full),
      .r_push  (r_push),
      .r_data  (r_data)
   );

   // Result queue
   phsq_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (r_push),
      .wdata (r_data),
      .full  (r_full),
      .pop   (pop),
      .rdata (r_head),
      .empty (empty)
   );

   assign rsp_echo_seq       = r_head.echo_seq;
   assign rsp_echo_client    = r_head.echo_client;
   assign rsp_status         = r_head.status;
   assign rsp_post_valid     = r_head.post_valid;
   assign rsp_out_post_id    = r_head.post_id;
   assign rsp_out_post_time  = r_head.post_time;
   assign rsp_out_payload    = r_head.payload;
   assign rsp_chunk_end      = r_head.chunk_end;
   assign rsp_last           = r_head.last;
   assign rsp_appended_count = r_head.appended;
   assign rsp_dropped_count  = r_head.dropped;

endmodule

// ----- tb/phsq_checker.sv -----
// Watches both channels of the post store, keeps a shadow copy of the ring,
// predicts the results of every accepted request and checks them in order.
module phsq_checker
   import phsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key_post_id,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_post_payload,
   input  logic [15:0] req_seq_num,
   input  logic [7:0]  req_client_slot,
   input  logic [15:0] req_limit,
   input  logic        empty,
   input  logic        pop,
   input  logic [15:0] rsp_echo_seq,
   input  logic [7:0]  rsp_echo_client,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_post_valid,
   input  logic [31:0] rsp_out_post_id,
   input  logic [31:0] rsp_out_post_time,
   input  logic [31:0] rsp_out_payload,
   input  logic        rsp_chunk_end,
   input  logic        rsp_last,
   input  logic [31:0] rsp_appended_count,
   input  logic [31:0] rsp_dropped_count,
   output int          errors,
   output int          pending
);

   localparam int RING = 64;
   localparam int CHUNK = 8;
   localparam int MAX_LIM = CHUNK * 8;

   // Shadow store
   logic [31:0] ring_id   [RING];
   logic [31:0] ring_time [RING];
   logic [31:0] ring_pay  [RING];
   logic [5:0]  fill_ptr;
   logic        wrapped;
   logic [31:0] n_appends;
   logic [31:0] n_drops;

   rsp_type expected_rsps[$];

   assign pending = expected_rsps.size();

   initial errors = 0;

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %h expected %h (seq %h)", field, got, want, rsp_echo_seq);
      errors++;
   endtask

   function automatic rsp_type blank_rsp(input logic [15:0] seq, input logic [7:0] cli,
                                         input status_type st);
      rsp_type r;
      r = '0;
      r.echo_seq = seq;
      r.echo_client = cli;
      r.status = st;
      r.last = 1'b1;
      r.appended = n_appends;
      r.dropped = n_drops;
      return r;
   endfunction

   function automatic bit id_stored(input logic [31:0] id);
      for (int i = 0; i < RING; i++)
         if (ring_id[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   // Work out the results of one request and update the shadow store
   task automatic predict_request(input action_type act, input logic [31:0] key,
                                  input logic [31:0] tval, input logic [31:0] pay,
                                  input logic [15:0] seq, input logic [7:0] cli,
                                  input logic [15:0] lim_in);
      int          hits[$];
      int          lim, first, cnt, tmp, j;
      logic [31:0] oldest;
      bit          m;
      rsp_type     r;
      if (act == ACT_APPEND) begin
         if (key == 0) begin
            expected_rsps.push_back(blank_rsp(seq, cli, STAT_REJECT));
            return;
         end
         if (!id_stored(key)) begin
            ring_id[fill_ptr] = key;
            ring_time[fill_ptr] = tval;
            ring_pay[fill_ptr] = pay;
            if (fill_ptr == RING - 1) wrapped = 1'b1;
            fill_ptr = fill_ptr + 1;
            n_appends = n_appends + 1;
            if (wrapped) n_drops = n_drops + 1;
         end
         expected_rsps.push_back(blank_rsp(seq, cli, STAT_OK));
         return;
      end
      lim = (lim_in == 0) ? 1 : (lim_in > MAX_LIM) ? MAX_LIM : lim_in;
      // History gap: listing after an id older than everything stored
      if (act == ACT_AFTER && key != 0) begin
         oldest = 32'hFFFF_FFFF;
         for (int i = 0; i < RING; i++)
            if (ring_id[i] != 0 && ring_id[i] < oldest) oldest = ring_id[i];
         if (oldest != 32'hFFFF_FFFF && key < oldest) begin
            expected_rsps.push_back(blank_rsp(seq, cli, STAT_GAP));
            return;
         end
      end
      for (int i = 0; i < RING; i++) begin
         case (act)
            ACT_NEWEST: m = ring_id[i] != 0;
            ACT_AFTER:  m = ring_id[i] > key;
            default:    m = ring_id[i] != 0 && ring_time[i] > tval;
         endcase
         if (m) hits.push_back(i);
      end
      // Ascending id order
      for (int i = 1; i < hits.size(); i++) begin
         tmp = hits[i];
         j = i;
         while (j > 0 && ring_id[hits[j-1]] > ring_id[tmp]) begin
            hits[j] = hits[j-1];
            j--;
         end
         hits[j] = tmp;
      end
      cnt = hits.size();
      first = 0;
      if (act == ACT_NEWEST) begin
         if (cnt > lim) first = cnt - lim;
      end else if (cnt > lim) begin
         cnt = lim;
      end
      if (cnt == first) begin
         expected_rsps.push_back(blank_rsp(seq, cli, STAT_OK));
         return;
      end
      for (int i = first; i < cnt; i++) begin
         r = blank_rsp(seq, cli, STAT_OK);
         r.post_valid = 1'b1;
         r.post_id = ring_id[hits[i]];
         r.post_time = ring_time[hits[i]];
         r.payload = ring_pay[hits[i]];
         r.last = (i + 1 == cnt);
         r.chunk_end = r.last || ((i - first + 1) % CHUNK == 0);
         expected_rsps.push_back(r);
      end
   endtask

   // Sample both handshakes at the clock edge
   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         for (int i = 0; i < RING; i++) begin
            ring_id[i] = '0;
            ring_time[i] = '0;
            ring_pay[i] = '0;
         end
         fill_ptr = '0;
         wrapped = 1'b0;
         n_appends = '0;
         n_drops = '0;
         expected_rsps.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected item", {16'h0, rsp_echo_seq}, 32'h0);
            end else begin
               w = expected_rsps.pop_front();
               if (rsp_echo_seq != w.echo_seq) report("echo_seq", rsp_echo_seq, w.echo_seq);
               if (rsp_echo_client != w.echo_client)
                  report("echo_client", rsp_echo_client, w.echo_client);
               if (rsp_status != w.status) report("status", rsp_status, w.status);
               if (rsp_post_valid != w.post_valid)
                  report("post_valid", rsp_post_valid, w.post_valid);
               if (rsp_out_post_id != w.post_id) report("post_id", rsp_out_post_id, w.post_id);
               if (rsp_out_post_time != w.post_time)
                  report("post_time", rsp_out_post_time, w.post_time);
               if (rsp_out_payload != w.payload) report("payload", rsp_out_payload, w.payload);
               if (rsp_chunk_end != w.chunk_end)
                  report("chunk_end", rsp_chunk_end, w.chunk_end);
               if (rsp_last != w.last) report("last", rsp_last, w.last);
               if (rsp_appended_count != w.appended)
                  report("appended_count", rsp_appended_count, w.appended);
               if (rsp_dropped_count != w.dropped)
                  report("dropped_count", rsp_dropped_count, w.dropped);
            end
         end
         if (push && !full)
            predict_request(action_type'(req_action), req_key_post_id, req_time_value,
                            req_post_payload, req_seq_num, req_client_slot, req_limit);
      end
   end

endmodule

// ----- tb/tb.sv -----
module tb;
   import phsq_pkg::*;

   localparam int IDLE_LIMIT = 30000;
   localparam int HOLD_CYCLES = 1500;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_action;
   logic [31:0] req_key_post_id;
   logic [31:0] req_time_value;
   logic [31:0] req_post_payload;
   logic [15:0] req_seq_num;
   logic [7:0]  req_client_slot;
   logic [15:0] req_limit;
   logic        empty;
   logic        pop;
   logic [15:0] rsp_echo_seq;
   logic [7:0]  rsp_echo_client;
   logic [1:0]  rsp_status;
   logic        rsp_post_valid;
   logic [31:0] rsp_out_post_id;
   logic [31:0] rsp_out_post_time;
   logic [31:0] rsp_out_payload;
   logic        rsp_chunk_end;
   logic        rsp_last;
   logic [31:0] rsp_appended_count;
   logic [31:0] rsp_dropped_count;
   int          errors;
   int          pending;
   int          idle_cycles;
   logic [15:0] seq_no;
   logic [31:0] used_ids[$];

   post_history_store_query u_dut (.*);
   phsq_checker u_checker (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   task automatic send_item(input action_type act, input logic [31:0] key,
                            input logic [31:0] tval, input logic [31:0] pay,
                            input logic [15:0] lim);
      int gap;
      req_action <= act;
      req_key_post_id <= key;
      req_time_value <= tval;
      req_post_payload <= pay;
      req_seq_num <= seq_no;
      req_client_slot <= 8'($urandom_range(0, 255));
      req_limit <= lim;
      push <= 1'b1;
      seq_no = seq_no + 16'h1235;
      if (act == ACT_APPEND) used_ids.push_back(key);
      do @(posedge clock); while (full);
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_limit();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 16'($urandom_range(0, 10));
      if (p < 80) return 16'd64;
      if (p < 88) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [31:0] pick_old_id();
      if (used_ids.size() == 0) return $urandom();
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
   endfunction

   // Stimulus
   initial begin
      logic [31:0] key;
      int p;
      reset <= 1'b1;
      push <= 1'b0;
      req_action <= ACT_APPEND;
      req_key_post_id <= '0;
      req_time_value <= '0;
      req_post_payload <= '0;
      req_seq_num <= '0;
      req_client_slot <= '0;
      req_limit <= '0;
      seq_no = 16'hFFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, extremes, reject, duplicate, limits
      send_item(ACT_NEWEST, 32'h0, 32'h0, 32'h0, 16'd0);
      send_item(ACT_AFTER, 32'h5, 32'h0, 32'h0, 16'd3);
      send_item(ACT_SINCE, 32'h0, 32'h0, 32'h0, 16'hFFFF);
      send_item(ACT_APPEND, 32'h0, 32'h1234, 32'hFFFF_FFFF, 16'd0);
      send_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(ACT_APPEND, 32'h1, 32'h0, 32'h0, 16'd0);
      send_item(ACT_APPEND, 32'h100, 32'h50, 32'hA5A5_5A5A, 16'd0);
      send_item(ACT_APPEND, 32'h100, 32'h99, 32'h0, 16'd0);
      send_item(ACT_APPEND, 32'h200, 32'h60, 32'h5A5A_A5A5, 16'd0);
      send_item(ACT_NEWEST, 32'h0, 32'h0, 32'h0, 16'd2);
      send_item(ACT_NEWEST, 32'h0, 32'h0, 32'h0, 16'hFFFF);
      send_item(ACT_AFTER, 32'h0, 32'h0, 32'h0, 16'd64);
      send_item(ACT_AFTER, 32'h100, 32'h0, 32'h0, 16'd1);
      send_item(ACT_AFTER, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd5);
      send_item(ACT_SINCE, 32'h0, 32'h50, 32'h0, 16'd0);
      send_item(ACT_SINCE, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'd9);
      send_item(ACT_SINCE, 32'h0, 32'h0, 32'h0, 16'd65);

      // Random: mostly appends of fresh ids, queries between
      for (int n = 0; n < 85; n++) begin
         p = $urandom_range(0, 99);
         if (p < 68) begin
            p = $urandom_range(0, 99);
            if (p < 80) key = $urandom();
            else if (p < 95) key = pick_old_id();
            else key = 32'h0;
            send_item(ACT_APPEND, key, $urandom(), $urandom(),
                      16'($urandom_range(0, 65535)));
         end else if (p < 78) begin
            send_item(ACT_NEWEST, $urandom(), $urandom(), $urandom(), pick_limit());
         end else if (p < 90) begin
            p = $urandom_range(0, 3);
            key = (p == 0) ? $urandom_range(0, 1000) : (p == 1) ? $urandom() : pick_old_id();
            send_item(ACT_AFTER, key, $urandom(), $urandom(), pick_limit());
         end else begin
            send_item(ACT_SINCE, $urandom(), $urandom(), $urandom(), pick_limit());
         end
      end
      push <= 1'b0;
      @(posedge clock);

      // Drain, then let the block settle
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("post_history_store_query verification clean");
      end else begin
         $display("post_history_store_query verification failed");
      end
      $finish;
   end

   // Result side: long hold-off first so the input side backs up
   initial begin
      int gap;
      pop <= 1'b0;
      @(negedge reset);
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("post_history_store_query verification failed");
            $finish;
         end
      end
   end

endmodule
